// ===== rtl/core/servo_turnout_position_controller_defines.svh =====
// assertion macros for the servo turnout position controller
// used by the datapath module; expects i_clk and i_rst_n in scope
`ifndef SERVO_TURNOUT_POSITION_CONTROLLER_DEFINES_SVH
`define SERVO_TURNOUT_POSITION_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS
`define STPC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define STPC_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);
`else
`define STPC_ASSERT(lbl, prop, msg)
`define STPC_NEVER(lbl, expr, msg)
`endif

`endif

// ===== rtl/core/stpc_pkg.sv =====
// shared types and constants of the servo turnout position controller
// no dependencies
package stpc_pkg;

    // action codes carried in s_axis_tuser
    localparam logic [1:0] ACT_SET    = 2'd0;
    localparam logic [1:0] ACT_ADJUST = 2'd1;
    localparam logic [1:0] ACT_TICK   = 2'd2;

    // command codes carried in m_axis_tuser
    localparam logic CMD_DRIVE  = 1'b0;
    localparam logic CMD_CUTOFF = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_OFF_DELAY  = 2'd0;
    localparam logic [1:0] CFG_PULSE_ZERO = 2'd1;
    localparam logic [1:0] CFG_PULSE_FULL = 2'd2;

    localparam logic [15:0] OFF_DELAY_RST  = 16'd350;
    localparam logic [11:0] PULSE_ZERO_RST = 12'd204;
    localparam logic [11:0] PULSE_FULL_RST = 12'd408;
    localparam logic [7:0]  LOW_END_RST    = 8'd85;
    localparam logic [7:0]  HIGH_END_RST   = 8'd95;

    // divide by 180 as multiply by ceil(2^28 / 180) and shift
    localparam int          DEG_SPAN    = 180;
    localparam logic [20:0] RECIP_MULT  = 21'd1491309;
    localparam int          RECIP_SHIFT = 28;

    typedef struct packed {
        logic       pos;
        logic [7:0] high_end;
        logic [7:0] low_end;
    } t_entry;

    typedef struct packed {
        logic accept;
        logic mem_read;
        logic calc;
        logic mul;
        logic div;
        logic fix;
        logic pulse;
        logic load_out;
    } t_ctrl_cmd;

    typedef struct packed {
        logic [1:0] act;
        logic       set_ok;
        logic       tick_fire;
        logic       out_free;
    } t_ctrl_status;

endpackage

// ===== rtl/core/stpc_ctrl.sv =====
// sequencing state machine of the servo turnout position controller
// depends on stpc_pkg
module stpc_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_valid,
    output logic                  o_s_ready,
    input  stpc_pkg::t_ctrl_status i_status,
    output stpc_pkg::t_ctrl_cmd    o_cmd
);
    import stpc_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_CALC  = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_FIX   = 3'd5;
    localparam logic [2:0] S_PULSE = 3'd6;
    localparam logic [2:0] S_EMIT  = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       accept;

    assign o_s_ready = (r_state == S_IDLE);
    assign accept    = o_s_ready && i_s_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if ((i_status.act == ACT_SET && i_status.set_ok) ||
                        i_status.act == ACT_ADJUST) begin
                        n_state = S_READ;
                    end else if (i_status.act == ACT_TICK && i_status.tick_fire) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_READ:  n_state = S_CALC;
            S_CALC:  n_state = S_MUL;
            S_MUL:   n_state = S_DIV;
            S_DIV:   n_state = S_FIX;
            S_FIX:   n_state = S_PULSE;
            S_PULSE: n_state = S_EMIT;
            S_EMIT: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.accept   = accept;
        o_cmd.mem_read = (r_state == S_READ);
        o_cmd.calc     = (r_state == S_CALC);
        o_cmd.mul      = (r_state == S_MUL);
        o_cmd.div      = (r_state == S_DIV);
        o_cmd.fix      = (r_state == S_FIX);
        o_cmd.pulse    = (r_state == S_PULSE);
        o_cmd.load_out = (r_state == S_EMIT) && i_status.out_free;
    end

endmodule

// ===== rtl/core/stpc_datapath.sv =====
// endpoint table, tick counter, pulse mapping and output register
// depends on stpc_pkg and servo_turnout_position_controller_defines.svh
module stpc_datapath #(
    parameter int TURNOUT_COUNT = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  stpc_pkg::t_ctrl_cmd    i_cmd,
    output stpc_pkg::t_ctrl_status o_status,
    input  logic [15:0]            i_s_data,
    input  logic [1:0]             i_s_user,
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_index,
    input  logic [15:0]            i_cfg_data,
    output logic                   o_m_valid,
    input  logic                   i_m_ready,
    output logic [31:0]            o_m_data,
    output logic                   o_m_user
);
    import stpc_pkg::*;
    `include "servo_turnout_position_controller_defines.svh"

    localparam int         IDX_W   = (TURNOUT_COUNT > 1) ? $clog2(TURNOUT_COUNT) : 1;
    localparam logic [6:0] COUNT_L = 7'(TURNOUT_COUNT);

    // configuration
    logic [15:0] r_off_delay;
    logic [11:0] r_pulse_zero;
    logic [11:0] r_pulse_full;

    // control state
    logic [15:0]              r_elapsed;
    logic [3:0]               r_last_ch;
    logic [TURNOUT_COUNT-1:0] r_valid;
    logic                     r_out_valid;

    // endpoint table
    t_entry mem [TURNOUT_COUNT];

    // item and working registers
    logic [IDX_W-1:0] r_idx;
    logic             r_is_adj;
    logic             r_pos;
    logic [4:0]       r_step;
    t_entry           r_rd_entry;
    logic             r_rd_hit;
    logic [7:0]       r_deg;
    logic signed [21:0] r_prod;
    logic [20:0]      r_mag;
    logic             r_neg;
    logic [12:0]      r_q;

    // staged result
    logic       r_res_cmd;
    logic [3:0] r_res_ch;
    logic [11:0] r_res_pulse;
    logic       r_res_sv;
    logic [5:0] r_res_sa;
    logic [7:0] r_res_val;

    // output register
    logic       r_out_cmd;
    logic [3:0] r_out_ch;
    logic [11:0] r_out_pulse;
    logic       r_out_save_valid;
    logic [5:0] r_out_sa;
    logic [7:0] r_out_val;

    logic [3:0]  in_turnout;
    logic        in_pos;
    logic [4:0]  in_step;
    logic [3:0]  cur_ch;
    logic        set_ok;
    logic [15:0] tick_inc;
    logic        tick_fire;

    t_entry      ent;
    t_entry      wr_entry;
    logic        sel_pos;
    logic [7:0]  cur_deg;
    logic [7:0]  adj_deg;
    logic [7:0]  new_deg;

    logic signed [12:0] span;
    logic signed [21:0] prod;
    logic [21:0]        mag_full;
    logic [41:0]        recip_prod;
    logic [20:0]        q180;
    logic [20:0]        rem;
    logic signed [14:0] pulse_sum;
    logic [11:0]        pulse_sat;

    assign in_turnout = i_s_data[3:0];
    assign in_pos     = i_s_data[4];
    assign in_step    = i_s_data[9:5];

    assign cur_ch    = ({3'b0, r_last_ch} < COUNT_L) ? r_last_ch : 4'd0;
    assign set_ok    = ({3'b0, in_turnout} < COUNT_L);
    assign tick_inc  = (r_elapsed == 16'hFFFF) ? r_elapsed : r_elapsed + 16'd1;
    assign tick_fire = (tick_inc >= r_off_delay);

    always_comb begin
        o_status           = '0;
        o_status.act       = i_s_user;
        o_status.set_ok    = set_ok;
        o_status.tick_fire = tick_fire;
        o_status.out_free  = !r_out_valid || i_m_ready;
    end

    // entry lookup and endpoint adjust; unwritten entries read as reset ends
    always_comb begin
        if (r_rd_hit) begin
            ent = r_rd_entry;
        end else begin
            ent.pos      = 1'b0;
            ent.high_end = HIGH_END_RST;
            ent.low_end  = LOW_END_RST;
        end
        sel_pos  = r_is_adj ? ent.pos : r_pos;
        cur_deg  = sel_pos ? ent.high_end : ent.low_end;
        adj_deg  = cur_deg + {{3{r_step[4]}}, r_step};
        new_deg  = r_is_adj ? adj_deg : cur_deg;
        wr_entry.pos      = sel_pos;
        wr_entry.high_end = (r_is_adj && sel_pos)  ? adj_deg : ent.high_end;
        wr_entry.low_end  = (r_is_adj && !sel_pos) ? adj_deg : ent.low_end;
    end

    // pulse = pulse_zero + deg * (pulse_full - pulse_zero) / 180, truncated
    assign span       = $signed({1'b0, r_pulse_full}) - $signed({1'b0, r_pulse_zero});
    assign prod       = $signed({1'b0, r_deg}) * span;
    assign mag_full   = r_prod[21] ? (22'd0 - r_prod) : r_prod;
    assign recip_prod = mag_full[20:0] * RECIP_MULT;
    assign q180       = 21'({r_q, 7'd0}) + 21'({r_q, 5'd0}) + 21'({r_q, 4'd0})
                      + 21'({r_q, 2'd0});
    assign rem        = r_mag - q180;
    assign pulse_sum  = r_neg ? ($signed({3'b0, r_pulse_zero}) - $signed({2'b0, r_q}))
                              : ($signed({3'b0, r_pulse_zero}) + $signed({2'b0, r_q}));

    always_comb begin
        if (pulse_sum < 0) begin
            pulse_sat = 12'd0;
        end else if (pulse_sum > 15'sd4095) begin
            pulse_sat = 12'hFFF;
        end else begin
            pulse_sat = pulse_sum[11:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_delay  <= OFF_DELAY_RST;
            r_pulse_zero <= PULSE_ZERO_RST;
            r_pulse_full <= PULSE_FULL_RST;
            r_elapsed    <= '0;
            r_last_ch    <= '0;
            r_valid      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_OFF_DELAY:  r_off_delay  <= i_cfg_data;
                    CFG_PULSE_ZERO: r_pulse_zero <= i_cfg_data[11:0];
                    CFG_PULSE_FULL: r_pulse_full <= i_cfg_data[11:0];
                    default: ;
                endcase
            end
            if (i_cmd.accept) begin
                case (i_s_user)
                    ACT_SET: begin
                        if (set_ok) begin
                            r_last_ch <= in_turnout;
                            r_elapsed <= '0;
                        end
                    end
                    ACT_ADJUST: begin
                        r_last_ch <= cur_ch;
                        r_elapsed <= '0;
                    end
                    ACT_TICK: begin
                        r_elapsed <= tick_fire ? 16'd0 : tick_inc;
                    end
                    default: ;
                endcase
            end
            if (i_cmd.calc) r_valid[r_idx] <= 1'b1;
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) mem[r_idx] <= wr_entry;
        if (i_cmd.mem_read) begin
            r_rd_entry <= mem[r_idx];
            r_rd_hit   <= r_valid[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_step <= in_step;
            r_pos  <= in_pos;
            case (i_s_user)
                ACT_SET: begin
                    r_idx     <= IDX_W'(in_turnout);
                    r_is_adj  <= 1'b0;
                    r_res_cmd <= CMD_DRIVE;
                    r_res_ch  <= in_turnout;
                end
                ACT_ADJUST: begin
                    r_idx     <= IDX_W'(cur_ch);
                    r_is_adj  <= 1'b1;
                    r_res_cmd <= CMD_DRIVE;
                    r_res_ch  <= cur_ch;
                end
                default: begin
                    // cut-off result, only emitted when the tick fires
                    r_res_cmd   <= CMD_CUTOFF;
                    r_res_ch    <= cur_ch;
                    r_res_pulse <= '0;
                    r_res_sv    <= 1'b0;
                    r_res_sa    <= '0;
                    r_res_val   <= '0;
                end
            endcase
        end
        if (i_cmd.calc) begin
            r_deg     <= new_deg;
            r_res_sv  <= r_is_adj;
            r_res_sa  <= r_is_adj ? (6'({1'b0, r_res_ch, sel_pos}) + 6'd1) : 6'd0;
            r_res_val <= r_is_adj ? new_deg : 8'd0;
        end
        if (i_cmd.mul) r_prod <= prod;
        if (i_cmd.div) begin
            r_neg <= r_prod[21];
            r_mag <= mag_full[20:0];
            r_q   <= recip_prod[RECIP_SHIFT+12:RECIP_SHIFT];
        end
        if (i_cmd.fix && rem >= 21'(DEG_SPAN)) r_q <= r_q + 13'd1;
        if (i_cmd.pulse) r_res_pulse <= pulse_sat;
        if (i_cmd.load_out) begin
            r_out_cmd        <= r_res_cmd;
            r_out_ch         <= r_res_ch;
            r_out_pulse      <= r_res_pulse;
            r_out_save_valid <= r_res_sv;
            r_out_sa         <= r_res_sa;
            r_out_val        <= r_res_val;
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_m_user  = r_out_cmd;
    assign o_m_data  = {1'b0, r_out_val, r_out_sa, r_out_save_valid, r_out_pulse, r_out_ch};

    `STPC_ASSERT(a_load_when_free, i_cmd.load_out |-> (!r_out_valid || i_m_ready), "output overwritten while stalled")
    `STPC_ASSERT(a_cutoff_zero, (r_out_valid && r_out_cmd == CMD_CUTOFF) |-> (r_out_pulse == 12'd0 && r_out_sa == 6'd0), "cut-off carries pulse or save")
    `STPC_NEVER(a_save_on_cutoff, r_out_valid && r_out_save_valid && r_out_cmd == CMD_CUTOFF, "save request on a cut-off")
    `STPC_ASSERT(a_set_restarts, (i_cmd.accept && i_s_user == ACT_SET && set_ok) |=> (r_elapsed == 16'd0 && r_last_ch == $past(i_s_data[3:0])), "set did not restart the off timer")

endmodule

// ===== rtl/core/servo_turnout_position_controller.sv =====
// Servo turnout position controller, top level.
// Input stream: s_axis_tuser selects the action (set turnout, adjust endpoint,
// one millisecond tick); s_axis_tdata carries turnout, position and step.
// Output stream: m_axis_tuser is the command (drive or cut off); m_axis_tdata
// carries channel, pulse and the save request for an adjusted endpoint.
// Configuration: i_cfg_we writes off_delay (0), pulse_zero (1), pulse_full (2).
// Timing: a set or adjust item runs through lookup, write-back, multiply,
// reciprocal divide, correction and clamp in one shared datapath, and the next
// item is taken only after its result has been loaded into the output register.
// A tick that fires a cut-off goes straight to the output load; any other tick or an ignored item gives no output.
// The output register lets the next item enter while a result waits; a stalled
// receiver holds the block only when a new result is ready to be loaded.
// Reset: synchronous, active low; endpoints read as 85/95 until first written
// (per-entry valid bits, no clearing pass), registers return to their defaults,
// the off timer restarts so channel 0 is cut off after off_delay ticks.
module servo_turnout_position_controller #(
    parameter int TURNOUT_COUNT = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // turnout[3:0], position[4], step[9:5]
    input  logic [1:0]  s_axis_tuser,   // action[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // channel[3:0], pulse[15:4], save_valid[16],
                                        // save_address[22:17], save_value[30:23]
    output logic        m_axis_tuser,   // command[0]
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import stpc_pkg::*;

    t_ctrl_cmd    cmd;
    t_ctrl_status status;

    stpc_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_status  (status),
        .o_cmd     (cmd)
    );

    stpc_datapath #(
        .TURNOUT_COUNT (TURNOUT_COUNT)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_s_data    (s_axis_tdata),
        .i_s_user    (s_axis_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_m_valid   (m_axis_tvalid),
        .i_m_ready   (m_axis_tready),
        .o_m_data    (m_axis_tdata),
        .o_m_user    (m_axis_tuser)
    );

endmodule
